// ===== rtl/qkdp_pkg.sv =====
// ============================================================================
// qkdp_pkg
// Shared types and constants for the query/key dot product engine.
// ============================================================================
`default_nettype none

package qkdp_pkg;

  // Default sizing
  localparam int QKDP_MAX_PAIRS = 64;
  localparam int QKDP_MAX_KEYS  = 1024;

  // Field widths
  localparam int ELEM_W      = 32;
  localparam int SCORE_W     = 64;
  localparam int KEY_IDX_W   = 10;
  localparam int HEAD_PAIRS_W = 7;
  localparam int KEY_TOTAL_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;

  // Reset values of the configuration registers
  localparam logic [HEAD_PAIRS_W-1:0] HEAD_PAIRS_RST = 7'd64;
  localparam logic [KEY_TOTAL_W-1:0]  KEY_TOTAL_RST  = 11'd1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_PAIRS = 1'b0,
    CFG_KEY_TOTAL  = 1'b1
  } cfg_idx_t;

  // Item commands
  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_KEY   = 1'b1
  } cmd_t;

  // Input item
  typedef struct packed {
    logic                     command;
    logic signed [ELEM_W-1:0] elem_even;
    logic signed [ELEM_W-1:0] elem_odd;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [KEY_IDX_W-1:0]      key_index;
    logic                      last_key;
  } out_item_t;

  // Control that travels with an item down the pipeline
  typedef struct packed {
    logic                 valid;
    logic                 is_key;
    logic                 key_end;
    logic                 last_key;
    logic [KEY_IDX_W-1:0] key_index;
  } stage_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/qkdp_seq.sv =====
// ============================================================================
// qkdp_seq
// Configuration registers, query/key position tracking and the input stage.
// ============================================================================
`default_nettype none

module qkdp_seq #(
  parameter int MAX_PAIRS = qkdp_pkg::QKDP_MAX_PAIRS,
  parameter int MAX_KEYS  = qkdp_pkg::QKDP_MAX_KEYS,
  localparam int AW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
  localparam int KCW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [qkdp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qkdp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              accept,
  input  wire logic                              adv,
  input  wire qkdp_pkg::in_item_t                in_data,
  output qkdp_pkg::stage_ctrl_t                  s1_ctrl,
  output logic [AW-1:0]                          s1_addr,
  output logic signed [qkdp_pkg::ELEM_W-1:0]     s1_even,
  output logic signed [qkdp_pkg::ELEM_W-1:0]     s1_odd
);

  logic [qkdp_pkg::HEAD_PAIRS_W-1:0] head_pairs_r;
  logic [qkdp_pkg::KEY_TOTAL_W-1:0]  key_total_r;
  logic [AW-1:0]  qwp_r, qwp_nxt;
  logic [AW-1:0]  kpos_r, kpos_nxt;
  logic [KCW-1:0] kc_r, kc_nxt;
  logic [31:0]    np, nk;
  logic [AW-1:0]  q_pos;
  logic           key_end, key_last, is_key;
  qkdp_pkg::stage_ctrl_t s1_ctrl_r;
  logic [AW-1:0]  s1_addr_r;
  logic signed [qkdp_pkg::ELEM_W-1:0] s1_even_r, s1_odd_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_pairs_r <= qkdp_pkg::HEAD_PAIRS_RST;
      key_total_r  <= qkdp_pkg::KEY_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (qkdp_pkg::cfg_idx_t'(cfg_index))
        qkdp_pkg::CFG_HEAD_PAIRS: head_pairs_r <= cfg_wdata[qkdp_pkg::HEAD_PAIRS_W-1:0];
        qkdp_pkg::CFG_KEY_TOTAL:  key_total_r  <= cfg_wdata[qkdp_pkg::KEY_TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts into their legal range
  always_comb begin
    if (head_pairs_r == '0)                      np = 32'd1;
    else if (32'(head_pairs_r) > 32'(MAX_PAIRS)) np = 32'(MAX_PAIRS);
    else                                         np = 32'(head_pairs_r);
    if (key_total_r == '0)                       nk = 32'd1;
    else if (32'(key_total_r) > 32'(MAX_KEYS))   nk = 32'(MAX_KEYS);
    else                                         nk = 32'(key_total_r);
  end

  // Position arithmetic
  always_comb begin
    is_key   = (in_data.command == qkdp_pkg::CMD_KEY);
    q_pos    = (32'(qwp_r) >= np) ? '0 : qwp_r;
    qwp_nxt  = ((32'(q_pos) + 32'd1) >= np) ? '0 : AW'(32'(q_pos) + 32'd1);
    key_end  = (32'(kpos_r) + 32'd1) >= np;
    kpos_nxt = key_end ? '0 : AW'(32'(kpos_r) + 32'd1);
    key_last = (32'(kc_r) + 32'd1) >= nk;
    kc_nxt   = key_last ? '0 : KCW'(32'(kc_r) + 32'd1);
  end

  // Advance positions on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qwp_r  <= '0;
      kpos_r <= '0;
      kc_r   <= '0;
    end else if (accept) begin
      if (is_key) begin
        kpos_r <= kpos_nxt;
        if (key_end) begin
          kc_r <= kc_nxt;
        end
      end else begin
        qwp_r <= qwp_nxt;
      end
    end
  end

  // Input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else if (adv) begin
      s1_ctrl_r.valid     <= accept;
      s1_ctrl_r.is_key    <= is_key;
      s1_ctrl_r.key_end   <= is_key && key_end;
      s1_ctrl_r.last_key  <= is_key && key_end && key_last;
      s1_ctrl_r.key_index <= qkdp_pkg::KEY_IDX_W'(kc_r);
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r <= is_key ? kpos_r : q_pos;
      s1_even_r <= in_data.elem_even;
      s1_odd_r  <= in_data.elem_odd;
    end
  end

  assign s1_ctrl = s1_ctrl_r;
  assign s1_addr = s1_addr_r;
  assign s1_even = s1_even_r;
  assign s1_odd  = s1_odd_r;

endmodule

`default_nettype wire

// ===== rtl/qkdp_mac.sv =====
// ============================================================================
// qkdp_mac
// Query memory, pair multipliers and the wrapping 64-bit accumulator.
// ============================================================================
`default_nettype none

module qkdp_mac #(
  parameter int MAX_PAIRS = qkdp_pkg::QKDP_MAX_PAIRS,
  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire qkdp_pkg::stage_ctrl_t             s1_ctrl,
  input  wire logic [AW-1:0]                     s1_addr,
  input  wire logic signed [qkdp_pkg::ELEM_W-1:0] s1_even,
  input  wire logic signed [qkdp_pkg::ELEM_W-1:0] s1_odd,
  output logic                                   res_valid,
  output qkdp_pkg::out_item_t                    res
);

  localparam int EW = qkdp_pkg::ELEM_W;
  localparam int SW = qkdp_pkg::SCORE_W;

  logic [2*EW-1:0] qmem [MAX_PAIRS];
  logic [2*EW-1:0] q_r;
  qkdp_pkg::stage_ctrl_t c2_r, c3_r;
  logic signed [EW-1:0] e2_even_r, e2_odd_r;
  logic signed [SW-1:0] p0_r, p1_r;
  logic signed [SW-1:0] acc_r, sum;

  // Query memory: write query pairs, read the pair for a key
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_ctrl.valid && !s1_ctrl.is_key) begin
        qmem[s1_addr] <= {s1_odd, s1_even};
      end
      q_r <= qmem[s1_addr];
    end
  end

  // Stage 2 and 3 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
      c3_r <= '0;
    end else if (adv) begin
      c2_r <= s1_ctrl;
      c3_r <= c2_r;
    end
  end

  // Hold key elements beside the memory read, then multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      e2_even_r <= s1_even;
      e2_odd_r  <= s1_odd;
      p0_r      <= $signed(q_r[EW-1:0]) * e2_even_r;
      p1_r      <= $signed(q_r[2*EW-1:EW]) * e2_odd_r;
    end
  end

  assign sum = acc_r + p0_r + p1_r;

  // Accumulate; clear at the end of each key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv && c3_r.valid && c3_r.is_key) begin
      acc_r <= c3_r.key_end ? '0 : sum;
    end
  end

  assign res_valid     = c3_r.valid && c3_r.key_end;
  assign res.score     = sum;
  assign res.key_index = c3_r.key_index;
  assign res.last_key  = c3_r.last_key;

endmodule

`default_nettype wire

// ===== rtl/query_key_dot_product.sv =====
// ============================================================================
// query_key_dot_product
// Attention score engine: loads a query vector in element pairs, then scores
// streamed key vectors against it with a wrapping 64-bit accumulator.
// ============================================================================
//
//   channel  ports                          direction  role
//   in_      in_valid, in_ready, in_data    input      query or key element pair
//   out_     out_valid, out_ready, out_data output     score, key index, last flag
//   cfg_     cfg_we, cfg_index, cfg_wdata   input      head_pairs, key_total
//
// One item per cycle while the output is not stalled. An item passes the input
// register, the query memory read register and the multiplier register; the
// accumulator sum then loads the output register, and out_valid rises once
// the last pair of a key has reached it.
// Reset clears positions, counters and the accumulator; the query memory
// holds garbage until written. A stalled output freezes the whole pipeline.
// ============================================================================
`default_nettype none

module query_key_dot_product #(
  parameter int MAX_PAIRS = qkdp_pkg::QKDP_MAX_PAIRS,
  parameter int MAX_KEYS  = qkdp_pkg::QKDP_MAX_KEYS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [qkdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qkdp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire qkdp_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output qkdp_pkg::out_item_t                  out_data
);

  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic adv, accept, res_valid;
  qkdp_pkg::stage_ctrl_t s1_ctrl;
  logic [AW-1:0] s1_addr;
  logic signed [qkdp_pkg::ELEM_W-1:0] s1_even, s1_odd;
  qkdp_pkg::out_item_t res;
  logic out_valid_r;
  qkdp_pkg::out_item_t out_data_r;

  // Advance the pipeline unless a result is waiting and out_ready is low
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  qkdp_seq #(
    .MAX_PAIRS (MAX_PAIRS),
    .MAX_KEYS  (MAX_KEYS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .adv       (adv),
    .in_data   (in_data),
    .s1_ctrl   (s1_ctrl),
    .s1_addr   (s1_addr),
    .s1_even   (s1_even),
    .s1_odd    (s1_odd)
  );

  qkdp_mac #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_ctrl   (s1_ctrl),
    .s1_addr   (s1_addr),
    .s1_even   (s1_even),
    .s1_odd    (s1_odd),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // A last-key flag only rides on the final pair of a key
  a_last_on_key_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctrl.valid && s1_ctrl.last_key |-> s1_ctrl.is_key && s1_ctrl.key_end)
    else $error("last_key set on an item that does not end a key");

  // Query pairs never end a key
  a_query_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctrl.valid && !s1_ctrl.is_key |-> !s1_ctrl.key_end)
    else $error("query item marked as key end");

  // The output register loads exactly what the accumulator stage produced
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid |=> out_valid && out_data == $past(res))
    else $error("output register lost a result");
`endif

endmodule

`default_nettype wire
